[sv/best_fit_heap_allocator_top_macros.svh]
// Assertion macros for the best-fit heap allocator checker.
// Used by sv/bfha_checker.sv only.
`ifndef BEST_FIT_HEAP_ALLOCATOR_TOP_MACROS_SVH
`define BEST_FIT_HEAP_ALLOCATOR_TOP_MACROS_SVH
// Implication checked at every edge outside reset
`define BFHA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Condition at one edge implies a consequence at the next edge
`define BFHA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`endif

[sv/bfha_pkg.sv]
// Package for the best-fit heap allocator: constants, state type.
// No dependencies.
`timescale 1ns / 1ps
package bfha_pkg;
  localparam int unsigned HeapGranules = 4096;
  localparam int unsigned HeaderBytes  = 16;
  localparam int unsigned MaxRequest   = 65536;

  typedef enum logic [3:0] {
    ST_IDLE,   // waiting for a transaction
    ST_ARD,    // alloc walk: read issued
    ST_AEVAL,  // alloc walk: evaluate segment
    ST_AWR1,   // alloc: write rest, chosen
    ST_AWR2,   // alloc: fix back link after rest
    ST_FWALK,  // free: walk to validate start
    ST_FEVAL,
    ST_FLEFT,  // free: merge left
    ST_FLEV,
    ST_FRIGHT, // free: merge right
    ST_FREV,
    ST_FFIX,
    ST_DONE
  } state_e;
endpackage

[sv/best_fit_heap_allocator_top.sv]
// Top level of the best-fit heap allocator: control sequencer and segment stores.
// Depends on bfha_pkg.
`timescale 1ns / 1ps
// Best-fit heap allocator over HEAP_GRANULES granules of 16 bytes.
// Channels: input (in_valid / in_stall) carries action, request_bytes and
// free_address; output (out_valid / out_stall) carries success and
// block_address. Configuration: cfg_valid / cfg_ready writes heap_base.
// One transaction at a time. An allocate walks the segment chain, reading
// each segment from memory and then evaluating it; it then marks the best fit
// used, splits off and relinks the rest when enough is left over, and registers
// the answer. When nothing fits, or for an oversized request, it registers a
// failure. A free walks the chain to the address, then reads each neighbour
// on either side and merges it when free, relinks the right neighbour when
// one follows, and registers the answer.
// After reset a clearing pass over all HEAP_GRANULES entries writes the size store
// (entry zero to the whole heap, the rest to zero) and clears the used marks;
// no input is taken meanwhile. The result sits in an output register; while
// the receiver stalls it holds and no new input is taken. The next transaction
// is taken the cycle after the result leaves.
module best_fit_heap_allocator_top #(
  parameter int unsigned HEAP_GRANULES = bfha_pkg::HeapGranules,
  parameter int unsigned HEADER_BYTES  = bfha_pkg::HeaderBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action_i,
  input  logic [16:0] request_bytes_i,
  input  logic [31:0] free_address_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        success_o,
  output logic [31:0] block_address_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data_i
);
  localparam int unsigned AW = $clog2(HEAP_GRANULES);
  localparam int unsigned SW = AW + 1;
  localparam logic [SW-1:0] FULL = SW'(HEAP_GRANULES);
  localparam logic [SW-1:0] SPLIT_MIN = SW'((2 * HEADER_BYTES) / 16);

  bfha_pkg::state_e state_q, state_d;

  // memories
  logic [SW-1:0] size_mem [HEAP_GRANULES];
  logic [AW-1:0] prev_mem [HEAP_GRANULES];
  logic          used_mem [HEAP_GRANULES];

  logic [AW-1:0] rd_addr;
  logic [SW-1:0] rd_size_q;
  logic [AW-1:0] rd_prev_q;
  logic          rd_used_q;
  logic          sz_we, pv_we, us_we;
  logic [AW-1:0] sz_wa, pv_wa, us_wa;
  logic [SW-1:0] sz_wd;
  logic [AW-1:0] pv_wd;
  logic          us_wd;

  always_ff @(posedge clk_i) begin
    rd_size_q <= size_mem[rd_addr];
    rd_prev_q <= prev_mem[rd_addr];
    rd_used_q <= used_mem[rd_addr];
    if (sz_we) size_mem[sz_wa] <= sz_wd;
    if (pv_we) prev_mem[pv_wa] <= pv_wd;
    if (us_we) used_mem[us_wa] <= us_wd;
  end

  // working registers
  logic          clr_busy_q;
  logic [AW-1:0] clr_q;
  logic [31:0]   base_q;
  logic [SW-1:0] pos_q, pos_d;      // walk position (may reach HEAP_GRANULES)
  logic [SW-1:0] need_q, need_d;
  logic          found_q, found_d;
  logic [AW-1:0] best_q, best_d;
  logic [SW-1:0] bsize_q, bsize_d;
  logic [AW-1:0] seg_q, seg_d;      // free: segment being merged into
  logic [SW-1:0] ssize_q, ssize_d;  // its size
  logic [AW-1:0] tgt_q, tgt_d;      // free: target start
  logic          ok_q, ok_d;
  logic [31:0]   res_q, res_d;
  logic          ov_q;
  logic          os_q;
  logic [31:0]   oa_q;

  logic          accept;
  logic [31:0]   fdiff;
  logic [SW-1:0] req_g;
  logic [SW-1:0] nxt_pos;

  assign in_stall  = (state_q != bfha_pkg::ST_IDLE) || clr_busy_q || ov_q;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = ov_q;
  assign success_o = os_q;
  assign block_address_o = oa_q;
  assign fdiff = free_address_i - base_q - 32'(HEADER_BYTES);
  assign req_g = SW'((18'(request_bytes_i) + 18'(HEADER_BYTES) + 18'd15) >> 4);
  assign nxt_pos = pos_q + rd_size_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bfha_pkg::ST_IDLE:
        if (accept) begin
          if (action_i) state_d = bfha_pkg::ST_FWALK;
          else if (request_bytes_i > 17'(bfha_pkg::MaxRequest)) state_d = bfha_pkg::ST_DONE;
          else state_d = bfha_pkg::ST_ARD;
        end
      bfha_pkg::ST_ARD: state_d = bfha_pkg::ST_AEVAL;
      bfha_pkg::ST_AEVAL:
        if (rd_size_q == '0 || nxt_pos >= FULL) begin
          state_d = bfha_pkg::ST_DONE;
          if (found_d) state_d = bfha_pkg::ST_AWR1;
        end else state_d = bfha_pkg::ST_ARD;
      bfha_pkg::ST_AWR1:
        state_d = (bsize_q - need_q > SPLIT_MIN) ? bfha_pkg::ST_AWR2 : bfha_pkg::ST_DONE;
      bfha_pkg::ST_AWR2: state_d = bfha_pkg::ST_DONE;
      bfha_pkg::ST_FWALK: state_d = bfha_pkg::ST_FEVAL;
      bfha_pkg::ST_FEVAL:
        if (pos_q[AW-1:0] == tgt_q)
          state_d = (rd_used_q) ? bfha_pkg::ST_FLEFT : bfha_pkg::ST_DONE;
        else if (rd_size_q == '0 || nxt_pos > SW'(tgt_q) || nxt_pos >= FULL)
          state_d = bfha_pkg::ST_DONE;
        else state_d = bfha_pkg::ST_FWALK;
      bfha_pkg::ST_FLEFT: state_d = (seg_q == '0) ? bfha_pkg::ST_FRIGHT : bfha_pkg::ST_FLEV;
      bfha_pkg::ST_FLEV:
        state_d = (rd_used_q) ? bfha_pkg::ST_FRIGHT : bfha_pkg::ST_FLEFT;
      bfha_pkg::ST_FRIGHT:
        state_d = (SW'(seg_q) + ssize_q >= FULL) ? bfha_pkg::ST_DONE : bfha_pkg::ST_FREV;
      bfha_pkg::ST_FREV:
        state_d = (rd_used_q) ? bfha_pkg::ST_FFIX : bfha_pkg::ST_FRIGHT;
      bfha_pkg::ST_FFIX: state_d = bfha_pkg::ST_DONE;
      bfha_pkg::ST_DONE: state_d = bfha_pkg::ST_IDLE;
      default: state_d = bfha_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    pos_d = pos_q; need_d = need_q; found_d = found_q; best_d = best_q;
    bsize_d = bsize_q; seg_d = seg_q; ssize_d = ssize_q; tgt_d = tgt_q;
    ok_d = ok_q; res_d = res_q;
    rd_addr = pos_q[AW-1:0];
    sz_we = 1'b0; pv_we = 1'b0; us_we = 1'b0;
    sz_wa = '0; pv_wa = '0; us_wa = '0;
    sz_wd = '0; pv_wd = '0; us_wd = 1'b0;
    if (clr_busy_q) begin
      sz_we = 1'b1; sz_wa = clr_q; sz_wd = (clr_q == '0) ? FULL : '0;
      us_we = 1'b1; us_wa = clr_q;
    end
    unique case (state_q)
      bfha_pkg::ST_IDLE: begin
        pos_d = '0; found_d = 1'b0; ok_d = 1'b0; res_d = '0; bsize_d = '0;
        need_d = req_g;
        tgt_d = fdiff[AW+3:4];
        if (accept && action_i &&
            (fdiff[3:0] != 4'd0 || (fdiff >> 4) >= 32'(HEAP_GRANULES)))
          tgt_d = '1;
      end
      bfha_pkg::ST_AEVAL: begin
        if (!rd_used_q && rd_size_q != '0 && rd_size_q > need_q &&
            (!found_q || rd_size_q < bsize_q)) begin
          found_d = 1'b1; best_d = pos_q[AW-1:0]; bsize_d = rd_size_q;
        end
        pos_d = nxt_pos;
      end
      bfha_pkg::ST_AWR1: begin
        us_we = 1'b1; us_wa = best_q; us_wd = 1'b1;
        ok_d = 1'b1;
        res_d = base_q + {28'(best_q), 4'd0} + 32'(HEADER_BYTES);
        if (bsize_q - need_q > SPLIT_MIN) begin
          sz_we = 1'b1; sz_wa = best_q + need_q[AW-1:0]; sz_wd = bsize_q - need_q;
          pv_we = 1'b1; pv_wa = best_q + need_q[AW-1:0]; pv_wd = best_q;
        end
      end
      bfha_pkg::ST_AWR2: begin
        // free rest used mark, shrink chosen, relink successor
        us_we = 1'b1; us_wa = best_q + need_q[AW-1:0]; us_wd = 1'b0;
        sz_we = 1'b1; sz_wa = best_q; sz_wd = need_q;
        if (SW'(best_q) + bsize_q < FULL) begin
          pv_we = 1'b1; pv_wa = AW'(SW'(best_q) + bsize_q); pv_wd = best_q + need_q[AW-1:0];
        end
      end
      bfha_pkg::ST_FEVAL: begin
        if (pos_q[AW-1:0] == tgt_q && pos_q < FULL) begin
          seg_d = tgt_q; ssize_d = rd_size_q;
          if (rd_used_q) begin
            ok_d = 1'b1; us_we = 1'b1; us_wa = tgt_q; us_wd = 1'b0;
          end
          rd_addr = rd_prev_q;
          pos_d = SW'(rd_prev_q);
        end else pos_d = nxt_pos;
      end
      bfha_pkg::ST_FLEFT: rd_addr = pos_q[AW-1:0];
      bfha_pkg::ST_FLEV:
        if (!rd_used_q) begin
          ssize_d = rd_size_q + ssize_q; seg_d = pos_q[AW-1:0];
          sz_we = 1'b1; sz_wa = pos_q[AW-1:0]; sz_wd = rd_size_q + ssize_q;
          rd_addr = rd_prev_q; pos_d = SW'(rd_prev_q);
        end
      bfha_pkg::ST_FRIGHT: rd_addr = AW'(SW'(seg_q) + ssize_q);
      bfha_pkg::ST_FREV:
        if (!rd_used_q) begin
          ssize_d = ssize_q + rd_size_q;
          sz_we = 1'b1; sz_wa = seg_q; sz_wd = ssize_q + rd_size_q;
        end
      bfha_pkg::ST_FFIX: begin
        pv_we = 1'b1; pv_wa = AW'(SW'(seg_q) + ssize_q); pv_wd = seg_q;
      end
      default: ;
    endcase
  end

  // registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfha_pkg::ST_IDLE;
      clr_busy_q <= 1'b1;
      clr_q <= '0;
      base_q <= '0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clr_busy_q) begin
        clr_q <= clr_q + 1'b1;
        if (clr_q == AW'(HEAP_GRANULES - 1)) clr_busy_q <= 1'b0;
      end
      if (cfg_valid && cfg_ready) base_q <= cfg_data_i;
      if (state_q == bfha_pkg::ST_DONE) ov_q <= 1'b1;
      else if (ov_q && !out_stall) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d; need_q <= need_d; found_q <= found_d; best_q <= best_d;
    bsize_q <= bsize_d; seg_q <= seg_d; ssize_q <= ssize_d; tgt_q <= tgt_d;
    ok_q <= ok_d; res_q <= res_d;
    if (state_q == bfha_pkg::ST_DONE) begin
      os_q <= ok_q;
      oa_q <= res_q;
    end
  end
endmodule

[sv/bfha_checker.sv]
// Port-level checker for the best-fit heap allocator, bound to the top level.
// Depends on best_fit_heap_allocator_top_macros.svh.
`timescale 1ns / 1ps
`include "best_fit_heap_allocator_top_macros.svh"
module bfha_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        success_o,
  input logic [31:0] block_address_o
);
  // a failed or free transaction never shows an address with success low
  `BFHA_ASSERT(a_fail_zero, clk_i, rst_ni, (out_valid && !success_o) |-> (block_address_o == 32'd0), "address on failure")
  // stalled result holds
  `BFHA_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid && out_stall, out_valid && $stable(block_address_o), "result dropped")
  // one transaction in flight: no input taken while a result waits
  `BFHA_ASSERT(a_one, clk_i, rst_ni, out_valid |-> in_stall, "input taken with result pending")
  // an accepted transaction cannot be answered in the very next cycle
  `BFHA_ASSERT_NEXT(a_lat, clk_i, rst_ni, in_valid && !in_stall, !out_valid, "result too early")
endmodule

bind best_fit_heap_allocator_top bfha_checker u_bfha_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .success_o(success_o),
  .block_address_o(block_address_o)
);

[tb/best_fit_heap_allocator_top_tb.sv]
// Self-checking testbench for best_fit_heap_allocator_top: directed and random allocate/free traffic
// against a behavioural heap predictor held in a small scoreboard class. Depends on bfha_pkg.
`timescale 1ns / 1ps
module best_fit_heap_allocator_top_tb;

  localparam int unsigned Granules = bfha_pkg::HeapGranules;
  localparam logic        ActAlloc = 1'b0;
  localparam logic        ActFree  = 1'b1;
  localparam int unsigned IdleLimit = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        action_i = 1'b0;
  logic [16:0] request_bytes_i = '0;
  logic [31:0] free_address_i = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        success_o;
  logic [31:0] block_address_o;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data_i = '0;

  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_off = 1'b0;
  logic [31:0] live_blocks[$];

  typedef struct packed {
    logic        ok;
    logic [31:0] addr;
  } heap_result_t;

  always #2 clk_i = ~clk_i;

  best_fit_heap_allocator_top dut (.*);

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    fail_count++;
  endtask

  // Heap predictor and the queue of pending answers
  class heap_scoreboard;
    logic [31:0]  base;
    int unsigned  seg_size[Granules];
    int unsigned  seg_prev[Granules];
    bit           seg_used[Granules];
    heap_result_t pending[$];

    function void clear();
      base = '0;
      foreach (seg_size[i]) begin
        seg_size[i] = 0;
        seg_prev[i] = 0;
        seg_used[i] = 0;
      end
      seg_size[0] = Granules;
    endfunction

    function bit starts_segment(int unsigned idx);
      int unsigned i;
      i = 0;
      while (i < Granules) begin
        if (i == idx) return 1'b1;
        if (seg_size[i] == 0 || i > idx) break;
        i += seg_size[i];
      end
      return 1'b0;
    endfunction

    function heap_result_t allocate(logic [16:0] req);
      int unsigned need, i, best, best_size, rest, after;
      bit found;
      heap_result_t r;
      r = '0;
      found = 0;
      i = 0;
      best = 0;
      best_size = 0;
      if (req > bfha_pkg::MaxRequest) return r;
      need = (req + bfha_pkg::HeaderBytes + 15) / 16;
      while (i < Granules) begin
        if (seg_size[i] == 0) break;
        if (!seg_used[i] && seg_size[i] > need && (!found || seg_size[i] < best_size)) begin
          found = 1;
          best = i;
          best_size = seg_size[i];
        end
        i += seg_size[i];
      end
      if (!found) return r;
      if ((best_size - need) * 16 > 2 * bfha_pkg::HeaderBytes) begin
        rest = best + need;
        after = best + best_size;
        seg_size[rest] = best_size - need;
        seg_prev[rest] = best;
        seg_used[rest] = 0;
        seg_size[best] = need;
        if (after < Granules) seg_prev[after] = rest;
      end
      seg_used[best] = 1;
      r.ok = 1'b1;
      r.addr = base + 32'(best * 16) + 32'(bfha_pkg::HeaderBytes);
      return r;
    endfunction

    function bit release_block(logic [31:0] addr);
      logic [31:0] d;
      int unsigned seg, p, nxt;
      d = addr - base - 32'(bfha_pkg::HeaderBytes);
      if (d[3:0] != 0) return 0;
      if ((d >> 4) >= Granules) return 0;
      seg = d >> 4;
      if (!starts_segment(seg) || !seg_used[seg]) return 0;
      seg_used[seg] = 0;
      while (seg != 0) begin
        p = seg_prev[seg];
        if (p >= Granules || seg_used[p]) break;
        seg_size[p] += seg_size[seg];
        seg = p;
      end
      forever begin
        nxt = seg + seg_size[seg];
        if (nxt >= Granules || seg_used[nxt]) break;
        seg_size[seg] += seg_size[nxt];
      end
      if (nxt < Granules) seg_prev[nxt] = seg;
      return 1;
    endfunction

    function void note_request(logic act, logic [16:0] req, logic [31:0] addr);
      heap_result_t r;
      if (act == ActAlloc) begin
        r = allocate(req);
        if (r.ok) live_blocks.push_back(r.addr);
      end else begin
        r = '0;
        r.ok = release_block(addr);
      end
      pending.push_back(r);
    endfunction

    task check_result(logic ok, logic [31:0] addr);
      heap_result_t w;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", addr, 32'd0);
      end else begin
        w = pending.pop_front();
        if (ok !== w.ok) report_mismatch("success", 32'(ok), 32'(w.ok));
        if (addr !== w.addr) report_mismatch("block_address", addr, w.addr);
      end
    endtask
  endclass

  heap_scoreboard heap_sb = new();

  // Sample all three channels at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        heap_sb.note_request(action_i, request_bytes_i, free_address_i);
      end
      if (out_valid && !out_stall) begin
        heap_sb.check_result(success_o, block_address_o);
      end
      if (cfg_valid && cfg_ready) begin
        heap_sb.base = cfg_data_i;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog; idle_cycles also runs over the clearing pass
  always @(posedge clk_i) begin
    if (idle_cycles >= IdleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver stall
  always @(negedge clk_i) begin
    out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  // Valid stays up after acceptance until the next transaction or an idle
  // cycle replaces it; the block is busy in between
  task automatic send_request(input logic act, input logic [16:0] req,
                              input logic [31:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    action_i <= act;
    request_bytes_i <= req;
    free_address_i <= addr;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (heap_sb.pending.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_base(input logic [31:0] value);
    logic [31:0] delta;
    wait_drained();
    // keep live payload addresses valid under the new base
    delta = value - heap_sb.base;
    foreach (live_blocks[i]) live_blocks[i] += delta;
    cfg_valid <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [16:0] random_size();
    case ($urandom_range(9))
      0: return 17'($urandom_range(131071));
      1, 2: return 17'($urandom_range(4096));
      default: return 17'($urandom_range(400));
    endcase
  endfunction

  task automatic random_traffic(input int count);
    int unsigned k;
    for (int n = 0; n < count; n++) begin
      if (live_blocks.size() > 0 && $urandom_range(99) < 45) begin
        k = $urandom_range(live_blocks.size() - 1);
        send_request(ActFree, 17'($urandom), live_blocks[k]);
        live_blocks.delete(k);
      end else if ($urandom_range(99) < 8) begin
        send_request(ActFree, 17'($urandom), $urandom);
      end else begin
        send_request(ActAlloc, random_size(), $urandom);
      end
    end
  endtask

  // Stimulus
  initial begin
    logic [31:0] a;
    heap_sb.clear();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, exact fit, oversize, bad frees
    write_base(32'hFFFF_FF00);
    send_request(ActAlloc, 17'd0, '0);
    send_request(ActAlloc, 17'd65536, '0);
    send_request(ActAlloc, 17'd65537, '0);
    send_request(ActAlloc, 17'h1FFFF, '0);
    send_request(ActAlloc, 17'd1, '0);
    send_request(ActAlloc, 17'd48, '0);
    send_request(ActFree, '0, 32'hFFFF_FF10 + 32'd16);
    send_request(ActFree, '0, 32'hFFFF_FF10 + 32'd16);
    send_request(ActFree, '0, 32'hFFFF_FF13);
    send_request(ActFree, '0, 32'hFFFF_FFFF);
    send_request(ActFree, '0, 32'h0000_0000);
    write_base(32'h0000_0000);
    live_blocks.delete();
    send_request(ActFree, '0, 32'h0000_0010);
    send_request(ActAlloc, 17'd65519, '0);
    a = 32'h10;
    send_request(ActAlloc, 17'd16, '0);
    send_request(ActAlloc, 17'd100, '0);
    send_request(ActFree, '0, a);
    send_request(ActAlloc, 17'd32, '0);
    wait_drained();
    live_blocks.delete();
    foreach (heap_sb.seg_used[i])
      if (heap_sb.seg_used[i])
        live_blocks.push_back(heap_sb.base + 32'(i * 16) + 32'(bfha_pkg::HeaderBytes));

    // Random phases over idling modes; base written between phases
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 8 : 54) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 8 : 54) : 0;
      if (ph == 2) write_base($urandom);
      if (ph == 3) write_base(32'hFFFF_FFFF);
      if (ph == 2) write_base(32'h0000_0000);
      random_traffic(190);
    end

    // Long receiver hold-off while items keep coming
    hold_off = 1'b1;
    fork
      begin
        repeat (2000) @(negedge clk_i);
        hold_off = 1'b0;
      end
      begin
        random_traffic(30);
        wait_drained();
      end
    join
    wait_drained();
    repeat (100) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
